// ----- hdl/sle_pkg.sv -----
package sle_pkg;

   localparam int unsigned ADDR_W      = 8;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned LINE_W      = 9;
   localparam int unsigned SLOT_W      = 3;
   localparam int unsigned COUNT_W     = 4;
   localparam int unsigned MEM_DEPTH   = 256;
   localparam int unsigned REQ_TDATA_W = 24;
   localparam int unsigned RSP_TDATA_W = 56;

   // sprites with Y at or above this value are hidden
   localparam logic [BYTE_W-1:0] Y_LIMIT      = 8'd239;
   localparam logic [3:0]        SHORT_HEIGHT = 4'd7;
   localparam logic [3:0]        TALL_HEIGHT  = 4'd15;
   // attribute byte bits 2..4 read as zero on a register read; evaluation returns them as stored
   localparam logic [BYTE_W-1:0] ATTR_HIDDEN  = 8'h1C;
   localparam logic [1:0]        ATTR_OFFSET  = 2'd2;
   localparam logic [1:0]        X_OFFSET     = 2'd3;

   typedef enum logic [1:0] {
      OP_SET_ADDR = 2'd0,
      OP_WRITE    = 2'd1,
      OP_READ     = 2'd2,
      OP_EVAL     = 2'd3
   } sle_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_REG_PUSH,
      ST_SCAN,
      ST_FETCH,
      ST_EMIT,
      ST_OVF,
      ST_SUMMARY
   } sle_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  read_data;
      logic [SLOT_W-1:0]  slot;
      logic [BYTE_W-1:0]  sprite_y;
      logic [BYTE_W-1:0]  sprite_tile;
      logic [BYTE_W-1:0]  sprite_attr;
      logic [BYTE_W-1:0]  sprite_x;
      logic [COUNT_W-1:0] found_count;
      logic               sprite_zero_hit_line;
      logic               overflow;
      logic               is_summary;
      logic               last;
   } sle_result_type;

   typedef struct packed {
      logic           valid;
      sle_result_type result;
   } sle_push_type;

endpackage

// ----- hdl/sle_mem.sv -----
module sle_mem (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [sle_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [sle_pkg::BYTE_W-1:0]  wr_data,
   input  logic [sle_pkg::ADDR_W-1:0]  rd_addr,
   output logic [sle_pkg::BYTE_W-1:0]  rd_data
);
   import sle_pkg::*;

   logic [BYTE_W-1:0]    mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] valid_ff;
   logic [BYTE_W-1:0]    rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // entries never written read as zero
      rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/sle_range.sv -----
module sle_range (
   input  logic [sle_pkg::BYTE_W-1:0] y,
   input  logic [sle_pkg::LINE_W-1:0] line,
   input  logic                       tall,
   output logic                       hit
);
   import sle_pkg::*;

   logic [LINE_W:0] bottom;

   assign bottom = (LINE_W+1)'(y) + (LINE_W+1)'(tall ? TALL_HEIGHT : SHORT_HEIGHT);
   assign hit    = (y < Y_LIMIT) && (line >= LINE_W'(y)) && ((LINE_W+1)'(line) <= bottom);

endmodule

// ----- hdl/sle_seq.sv -----
module sle_seq #(
   parameter int unsigned SPRITE_COUNT = 64,
   parameter int unsigned LINE_SLOTS   = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_op,
   input  logic [sle_pkg::BYTE_W-1:0]  req_data,
   input  logic [sle_pkg::LINE_W-1:0]  req_scanline,
   input  logic                        out_free,
   output sle_pkg::sle_push_type       push,
   output logic                        wr_en,
   output logic [sle_pkg::ADDR_W-1:0]  wr_addr,
   output logic [sle_pkg::BYTE_W-1:0]  wr_data,
   output logic [sle_pkg::ADDR_W-1:0]  rd_addr,
   input  logic [sle_pkg::BYTE_W-1:0]  rd_data,
   output logic [sle_pkg::LINE_W-1:0]  scan_line,
   input  logic                        hit
);
   import sle_pkg::*;

   localparam int unsigned SPR_W = $clog2(SPRITE_COUNT);

   sle_state_type      state_ff, state_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [SPR_W-1:0]   n_ff, n_in;
   logic [1:0]         m_ff, m_in;
   logic [1:0]         byte_ff, byte_in;
   logic [COUNT_W-1:0] found_ff, found_in;
   logic               zero_ff, zero_in;
   logic               ovf_ff, ovf_in;
   logic [LINE_W-1:0]  line_ff, line_in;
   logic [BYTE_W-1:0]  y_ff, y_in;
   logic [BYTE_W-1:0]  tile_ff, tile_in;
   logic [BYTE_W-1:0]  attr_ff, attr_in;
   logic [BYTE_W-1:0]  x_ff, x_in;
   logic [BYTE_W-1:0]  rdata_ff, rdata_in;

   logic               last_sprite;
   logic               slots_full;
   logic [SPR_W-1:0]   n_inc;
   sle_op_type         op;

   function automatic logic [ADDR_W-1:0] sprite_addr(input logic [SPR_W-1:0] n,
                                                     input logic [1:0] m);
      return ADDR_W'({n, m});
   endfunction

   assign op          = sle_op_type'(req_op);
   assign last_sprite = (n_ff == SPR_W'(SPRITE_COUNT - 1));
   assign slots_full  = (found_ff == COUNT_W'(LINE_SLOTS - 1));
   assign n_inc       = n_ff + SPR_W'(1);
   assign scan_line   = line_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (op)
                  OP_READ: state_in = ST_READ_WAIT;
                  OP_EVAL: state_in = ST_SCAN;
                  default: state_in = ST_REG_PUSH;
               endcase
            end
         end
         ST_READ_WAIT: state_in = ST_REG_PUSH;
         ST_REG_PUSH: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = ST_FETCH;
            end else if (last_sprite) begin
               state_in = ST_SUMMARY;
            end
         end
         ST_FETCH: begin
            if (byte_ff == X_OFFSET) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               if (last_sprite) begin
                  state_in = ST_SUMMARY;
               end else if (slots_full) begin
                  state_in = ST_OVF;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_OVF: begin
            if (hit || last_sprite) state_in = ST_SUMMARY;
         end
         ST_SUMMARY: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      addr_in   = addr_ff;
      n_in      = n_ff;
      m_in      = m_ff;
      byte_in   = byte_ff;
      found_in  = found_ff;
      zero_in   = zero_ff;
      ovf_in    = ovf_ff;
      line_in   = line_ff;
      y_in      = y_ff;
      tile_in   = tile_ff;
      attr_in   = attr_ff;
      x_in      = x_ff;
      rdata_in  = rdata_ff;
      req_ready = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = addr_ff;
      wr_data   = req_data;
      rd_addr   = addr_ff;
      push      = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (op == OP_EVAL) rd_addr = '0;
            if (req_valid) begin
               case (op)
                  OP_SET_ADDR: begin
                     addr_in  = req_data;
                     rdata_in = '0;
                  end
                  OP_WRITE: begin
                     wr_en    = 1'b1;
                     addr_in  = addr_ff + 8'd1;
                     rdata_in = '0;
                  end
                  OP_EVAL: begin
                     n_in     = '0;
                     m_in     = '0;
                     found_in = '0;
                     zero_in  = 1'b0;
                     ovf_in   = 1'b0;
                     line_in  = req_scanline;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ_WAIT: begin
            rdata_in = (addr_ff[1:0] == ATTR_OFFSET) ? (rd_data & ~ATTR_HIDDEN) : rd_data;
         end
         ST_REG_PUSH: begin
            push.valid             = out_free;
            push.result.read_data  = rdata_ff;
            push.result.is_summary = 1'b1;
            push.result.last       = 1'b1;
         end
         ST_SCAN: begin
            if (hit) begin
               y_in    = rd_data;
               zero_in = zero_ff | (n_ff == '0);
               byte_in = 2'd1;
               rd_addr = sprite_addr(n_ff, 2'd1);
            end else begin
               n_in    = last_sprite ? n_ff : n_inc;
               rd_addr = sprite_addr(n_inc, 2'd0);
            end
         end
         ST_FETCH: begin
            case (byte_ff)
               2'd1:        tile_in = rd_data;
               ATTR_OFFSET: attr_in = rd_data;
               default:     x_in    = rd_data;
            endcase
            byte_in = byte_ff + 2'd1;
            rd_addr = sprite_addr(n_ff, byte_ff + 2'd1);
         end
         ST_EMIT: begin
            push.valid              = out_free;
            push.result.slot        = found_ff[SLOT_W-1:0];
            push.result.sprite_y    = y_ff;
            push.result.sprite_tile = tile_ff;
            push.result.sprite_attr = attr_ff;
            push.result.sprite_x    = x_ff;
            rd_addr                 = sprite_addr(n_inc, 2'd0);
            if (out_free) begin
               found_in = found_ff + 4'd1;
               if (!last_sprite) begin
                  n_in = n_inc;
                  m_in = 2'd0;
               end
            end
         end
         ST_OVF: begin
            // diagonal walk: byte index advances along with the sprite
            rd_addr = sprite_addr(n_inc, m_ff + 2'd1);
            if (hit) begin
               ovf_in = 1'b1;
            end else if (!last_sprite) begin
               n_in = n_inc;
               m_in = m_ff + 2'd1;
            end
         end
         ST_SUMMARY: begin
            push.valid                       = out_free;
            push.result.found_count          = found_ff;
            push.result.sprite_zero_hit_line = zero_ff;
            push.result.overflow             = ovf_ff;
            push.result.is_summary           = 1'b1;
            push.result.last                 = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         addr_ff  <= '0;
         n_ff     <= '0;
         m_ff     <= '0;
         byte_ff  <= '0;
         found_ff <= '0;
         zero_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         n_ff     <= n_in;
         m_ff     <= m_in;
         byte_ff  <= byte_in;
         found_ff <= found_in;
         zero_ff  <= zero_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff  <= line_in;
      y_ff     <= y_in;
      tile_ff  <= tile_in;
      attr_ff  <= attr_in;
      x_ff     <= x_in;
      rdata_ff <= rdata_in;
   end

   a_found_bound: assert property (@(posedge clock) disable iff (reset)
      found_ff <= COUNT_W'(LINE_SLOTS))
      else $error("line list count beyond slot total");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> out_free)
      else $error("result pushed into a full output register");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> found_ff == COUNT_W'(LINE_SLOTS))
      else $error("overflow set with line list not full");

   a_ovf_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OVF |-> found_ff == COUNT_W'(LINE_SLOTS))
      else $error("overflow walk entered early");

endmodule

// ----- hdl/sprite_line_evaluation.sv -----
// Sprite line evaluation: a 256-byte sprite attribute memory (sprites of four
// bytes: Y, tile, attribute, X) behind an auto-incrementing byte address, plus
// a scanline evaluator. Each request beat carries an op in req_tuser: set the
// address, write a byte (address then advances), read a byte (attribute bytes
// read with bits 2..4 clear, address holds), or evaluate a scanline. A
// register access returns one beat; an evaluation returns one beat per sprite
// found (up to LINE_SLOTS) and then a summary beat with tlast set. All memory
// traffic goes through a single read port, so an evaluation reads sprite
// bytes one at a time; a hit in the overflow walk ends the walk early. The
// sequencer waits while the output register holds a beat not yet taken by
// rsp_tready. The block takes one request at a time and drops req_tready
// until the last result beat has been handed to the output register, which
// holds it until rsp_tready. Memory contents read as zero after reset
// without any clearing pass.
module sprite_line_evaluation #(
   parameter int unsigned SPRITE_COUNT = 64,
   parameter int unsigned LINE_SLOTS   = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: tdata = data[7:0], scanline[16:8], zero fill
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sle_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // request: tuser = op[1:0]
   input  logic [1:0]                          req_tuser,
   // result: tdata = read_data[7:0], slot[10:8], sprite_y[18:11],
   // sprite_tile[26:19], sprite_attr[34:27], sprite_x[42:35],
   // found_count[46:43], sprite_zero_hit_line[47], overflow[48], zero fill
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sle_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // result: tuser = is_summary
   output logic [0:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   // tall sprite select
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_data
);
   import sle_pkg::*;

   logic               tall_ff;
   logic               rsp_valid_ff;
   sle_result_type     rsp_result_ff;
   logic               out_free;
   sle_push_type       push;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [BYTE_W-1:0]  wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic [BYTE_W-1:0]  rd_data;
   logic [LINE_W-1:0]  scan_line;
   logic               hit;

   // configuration is taken at any time; the user must write it only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tall_ff <= 1'b0;
      end else if (csr_valid) begin
         tall_ff <= csr_data;
      end
   end

   sle_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared in-range test: serves both the main scan and the overflow walk
   sle_range u_range (
      .y    (rd_data),
      .line (scan_line),
      .tall (tall_ff),
      .hit  (hit)
   );

   sle_seq #(
      .SPRITE_COUNT (SPRITE_COUNT),
      .LINE_SLOTS   (LINE_SLOTS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_op       (req_tuser),
      .req_data     (req_tdata[7:0]),
      .req_scanline (req_tdata[16:8]),
      .out_free     (out_free),
      .push         (push),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .scan_line    (scan_line),
      .hit          (hit)
   );

   // output register: load a new beat when empty or when the held beat leaves
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         rsp_result_ff <= push.result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0,
                        rsp_result_ff.overflow,
                        rsp_result_ff.sprite_zero_hit_line,
                        rsp_result_ff.found_count,
                        rsp_result_ff.sprite_x,
                        rsp_result_ff.sprite_attr,
                        rsp_result_ff.sprite_tile,
                        rsp_result_ff.sprite_y,
                        rsp_result_ff.slot,
                        rsp_result_ff.read_data};
   assign rsp_tuser  = rsp_result_ff.is_summary;
   assign rsp_tlast  = rsp_result_ff.last;

endmodule
